// ===== sv/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  localparam int CODE_LENGTH = 8;
  localparam int CNT_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int BTN_W       = 8;
  localparam int KEY_W       = 4;
  localparam int POS_W       = 3;
  localparam int EV_W        = 3;
  localparam int HOLD_W      = 10;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(200);
  localparam logic [BTN_W-1:0]  BTN_KEY8_ONLY  = 8'h80;
  localparam logic [KEY_W-1:0]  KEY_EIGHT      = KEY_W'(8);
  localparam logic [CNT_W-1:0]  CNT_LAST       = CNT_W'(CODE_LENGTH - 1);

  localparam logic [0:0] REG_HOLD_TICKS = 1'b0;

  typedef enum logic [1:0] {
    MODE_ENTRY,
    MODE_HOLD,
    MODE_SET
  } mode_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE,
    EV_DIGIT,
    EV_UNLOCK,
    EV_REJECT,
    EV_SETMODE,
    EV_CODEDIGIT,
    EV_SAVED
  } event_e;

  typedef struct packed {
    event_e             event_res;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   key_value;
    logic               relay_pulse;
  } res_t;

  typedef struct packed {
    mode_e              mode;
    logic [CNT_W-1:0]   digit_count;
    logic [HOLD_W-1:0]  hold_count;
  } status_t;

  function automatic logic [KEY_W-1:0] decode_key(input logic [BTN_W-1:0] b);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = BTN_W - 1; i >= 0; i--) begin
      if (b[i]) begin
        k = KEY_W'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kcl_if.sv =====
// ----------------------------------------------------------------------------
// kcl_if
// Valid/ready channels for button samples and lock events.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_btn_if
  import kcl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] buttons;

  modport source (output valid, output buttons, input ready);
  modport sink   (input valid, input buttons, output ready);
endinterface

interface kcl_res_if
  import kcl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [EV_W-1:0]  event_res;
  logic [POS_W-1:0] position;
  logic [KEY_W-1:0] key_value;
  logic             relay_pulse;

  modport source (output valid, output event_res, output position, output key_value,
                  output relay_pulse, input ready);
  modport sink   (input valid, input event_res, input position, input key_value,
                  input relay_pulse, output ready);
endinterface

`default_nettype wire

// ===== sv/kcl_cfg.sv =====
// ----------------------------------------------------------------------------
// kcl_cfg
// APB register slice holding the key 8 hold threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_cfg
  import kcl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [HOLD_W-1:0]  hold_ticks_o
);

  logic [HOLD_W-1:0] hold_ticks_q;
  logic [HOLD_W-1:0] hold_ticks_d;
  logic              hit;

  assign hit    = (paddr[PADDR_W-1:2] == REG_HOLD_TICKS);
  assign pready = 1'b1;

  always_comb begin
    hold_ticks_d = hold_ticks_q;
    if (psel && penable && pwrite && pready && hit) begin
      hold_ticks_d = pwdata[HOLD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_TICKS_RST;
    end else begin
      hold_ticks_q <= hold_ticks_d;
    end
  end

  assign prdata       = hit ? PDATA_W'(hold_ticks_q) : '0;
  assign hold_ticks_o = hold_ticks_q;

endmodule

`default_nettype wire

// ===== sv/kcl_core.sv =====
// ----------------------------------------------------------------------------
// kcl_core
// Lock state, entry and code buffers, and the per-sample event decision.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_core
  import kcl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [BTN_W-1:0]  buttons_i,
  input  wire logic [HOLD_W-1:0] hold_ticks_i,
  output res_t                   res_o,
  output status_t                status_o
);

  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  logic              release_q, release_d;
  logic [KEY_W-1:0]  entered_q [CODE_LENGTH];
  logic [KEY_W-1:0]  stored_q  [CODE_LENGTH];

  logic [KEY_W-1:0]  key;
  logic              take;
  logic [KEY_W-1:0]  take_key;
  logic [KEY_W-1:0]  last_key;
  logic              match;
  logic              store_we;

  assign key      = decode_key(buttons_i);
  assign last_key = (mode_q == MODE_HOLD) ? KEY_EIGHT : key;

  always_comb begin
    match = (last_key == stored_q[CODE_LENGTH-1]);
    for (int i = 0; i < CODE_LENGTH - 1; i++) begin
      if (entered_q[i] != stored_q[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    hold_d    = hold_q;
    release_d = release_q;
    take      = 1'b0;
    take_key  = key;
    store_we  = 1'b0;
    res_o     = '{event_res: EV_NONE, position: '0, key_value: '0, relay_pulse: 1'b0};

    if (release_q) begin
      if (buttons_i == '0) begin
        release_d = 1'b0;
      end
    end else begin
      unique case (mode_q)
        MODE_HOLD: begin
          if (buttons_i[BTN_W-1]) begin
            if (hold_q >= hold_ticks_i) begin
              mode_d          = MODE_SET;
              count_d         = '0;
              hold_d          = '0;
              release_d       = 1'b1;
              res_o.event_res = EV_SETMODE;
            end else begin
              hold_d = hold_q + HOLD_W'(1);
            end
          end else begin
            mode_d    = MODE_ENTRY;
            hold_d    = '0;
            take      = 1'b1;
            take_key  = KEY_EIGHT;
            release_d = (buttons_i != '0);
          end
        end
        MODE_SET: begin
          if (key != '0) begin
            store_we        = 1'b1;
            release_d       = 1'b1;
            res_o.position  = POS_W'(count_q);
            res_o.key_value = key;
            if (count_q == CNT_LAST) begin
              count_d         = '0;
              mode_d          = MODE_ENTRY;
              res_o.event_res = EV_SAVED;
            end else begin
              count_d         = count_q + CNT_W'(1);
              res_o.event_res = EV_CODEDIGIT;
            end
          end
        end
        default: begin
          mode_d = MODE_ENTRY;
          if (key != '0) begin
            if (count_q == '0 && buttons_i == BTN_KEY8_ONLY) begin
              mode_d = MODE_HOLD;
              hold_d = HOLD_W'(1);
            end else begin
              take      = 1'b1;
              release_d = 1'b1;
            end
          end
        end
      endcase

      if (take) begin
        res_o.position  = POS_W'(count_q);
        res_o.key_value = take_key;
        if (count_q == CNT_LAST) begin
          count_d           = '0;
          res_o.event_res   = match ? EV_UNLOCK : EV_REJECT;
          res_o.relay_pulse = match;
        end else begin
          count_d         = count_q + CNT_W'(1);
          res_o.event_res = EV_DIGIT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_ENTRY;
      count_q   <= '0;
      hold_q    <= '0;
      release_q <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_q[i] <= KEY_W'((i % 8) + 1);
      end
    end else if (fire_i) begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      hold_q    <= hold_d;
      release_q <= release_d;
      if (store_we) begin
        stored_q[count_q] <= key;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && take) begin
      entered_q[count_q] <= take_key;
    end
  end

  assign status_o = '{mode: mode_q, digit_count: count_q, hold_count: hold_q};

endmodule

`default_nettype wire

// ===== sv/keypad_code_lock_controller.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// Keypad code lock: one button sample in, one lock event out per sample.
//
//   channel   dir   handshake       payload
//   btn_i     in    valid/ready     buttons[7:0]
//   res_o     out   valid/ready     event_res, position, key_value, relay_pulse
//   apb       in    psel/penable    hold_ticks at byte address 0
//
// A sample passes an input register, then one pass of state logic into the
// result register. One sample is taken every cycle while no result stalls.
// A stalled result holds the input register; btn_i.ready drops only when both
// are full. Reset clears control state, not entered digits, and loads code 1..8.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock_controller
  import kcl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  kcl_btn_if.sink                 btn_i,
  kcl_res_if.source               res_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic              in_v_q, in_v_d;
  logic [BTN_W-1:0]  in_btn_q;
  logic              out_v_q, out_v_d;
  res_t              out_q;
  res_t              core_res;
  status_t           status;
  logic [HOLD_W-1:0] hold_ticks;
  logic              advance;
  logic              take_in;

  kcl_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .hold_ticks_o (hold_ticks)
  );

  kcl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .buttons_i    (in_btn_q),
    .hold_ticks_i (hold_ticks),
    .res_o        (core_res),
    .status_o     (status)
  );

  assign advance     = in_v_q && (!out_v_q || res_o.ready);
  assign btn_i.ready = !in_v_q || advance;
  assign take_in     = btn_i.valid && btn_i.ready;

  always_comb begin
    in_v_d  = take_in ? 1'b1 : (advance ? 1'b0 : in_v_q);
    out_v_d = advance ? 1'b1 : ((res_o.ready) ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_btn_q <= btn_i.buttons;
    end
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.event_res   = out_q.event_res;
  assign res_o.position    = out_q.position;
  assign res_o.key_value   = out_q.key_value;
  assign res_o.relay_pulse = out_q.relay_pulse;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !advance |=> in_v_q && $stable(in_btn_q))
    else $error("input register lost a stalled sample");

  a_relay_unlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.relay_pulse |-> out_q.event_res == EV_UNLOCK)
    else $error("relay pulse without unlock");

  a_hold_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.mode == MODE_HOLD |-> status.digit_count == '0 && status.hold_count != '0)
    else $error("hold active past first digit");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.digit_count <= CNT_LAST)
    else $error("digit count out of range");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad code lock controller. Button samples go
// out over the valid/ready channel. A scoreboard keeps its own copy of the
// lock state and predicts one lock event per accepted sample. The event
// channel is compared field by field. Phases change hold_ticks over the
// config port, including both extremes, and run under different sender idle
// and receiver stall rates. Stimulus is a short directed run, then mostly
// well-formed code entries, code changes and key 8 holds, mixed with noise.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP   = 40;

  localparam logic [BTN_W-1:0] DIRECTED_SEQ [25] = '{
    8'h00, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h04, 8'h00, 8'h08, 8'h00,
    8'h10, 8'h00, 8'h20, 8'h00, 8'h40, 8'h00, 8'h80, 8'h00, 8'h80, 8'h80,
    8'hFE, 8'h00, 8'h80, 8'h00, 8'h01
  };

  typedef struct packed {
    mode_e                             mode;
    logic [4:0]                        digits;
    logic [CODE_LENGTH-1:0][KEY_W-1:0] entered;
    logic [CODE_LENGTH-1:0][KEY_W-1:0] stored;
    logic                              release_wait;
    logic [HOLD_W-1:0]                 hold_cnt;
    logic [HOLD_W-1:0]                 hold_ticks;
  } lock_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic             drv_valid   = 1'b0;
  logic [BTN_W-1:0] drv_buttons = '0;
  logic             rcv_ready   = 1'b0;

  kcl_btn_if btn_ch ();
  kcl_res_if res_ch ();

  assign btn_ch.valid   = drv_valid;
  assign btn_ch.buttons = drv_buttons;
  assign res_ch.ready   = rcv_ready;

  keypad_code_lock_controller u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .btn_i   (btn_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [BTN_W-1:0] btn_q[$];
  res_t             lock_q[$];
  lock_state_t      chk_st;
  lock_state_t      gst;
  res_t             due;
  int               send_idle_pct = 0;
  int               stall_pct     = 0;
  int               n_pushed      = 0;
  int               n_out         = 0;
  int               errors        = 0;
  int               quiet_cycles  = 0;
  int               ev_count [8]  = '{default: 0};

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    if (errors < PRINT_CAP) begin
      $display("MISMATCH event %0d: %s got %0d want %0d", n_out, what, got, exp_v);
    end
    errors++;
  endtask

  function automatic lock_state_t lock_reset();
    lock_state_t s;
    s = '0;
    s.mode = MODE_ENTRY;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      s.stored[i] = KEY_W'(i % 8 + 1);
    end
    s.hold_ticks = HOLD_TICKS_RST;
    return s;
  endfunction

  function automatic logic [KEY_W-1:0] lowest_key(input logic [BTN_W-1:0] b);
    for (int i = 0; i < BTN_W; i++) begin
      if (b[i]) begin
        return KEY_W'(i + 1);
      end
    end
    return '0;
  endfunction

  function automatic res_t take_digit(inout lock_state_t s, input logic [KEY_W-1:0] key);
    res_t r;
    r = '0;
    r.position  = s.digits[POS_W-1:0];
    r.key_value = key;
    s.entered[s.digits] = key;
    s.digits = s.digits + 5'd1;
    if (s.digits < CODE_LENGTH) begin
      r.event_res = EV_DIGIT;
    end else begin
      s.digits      = '0;
      r.event_res   = (s.entered == s.stored) ? EV_UNLOCK : EV_REJECT;
      r.relay_pulse = (s.entered == s.stored);
    end
    return r;
  endfunction

  function automatic res_t lock_step(inout lock_state_t s, input logic [BTN_W-1:0] b);
    res_t             r;
    logic [KEY_W-1:0] key;
    r = '0;
    r.event_res = EV_NONE;
    if (s.release_wait) begin
      if (b == '0) begin
        s.release_wait = 1'b0;
      end
      return r;
    end
    if (s.mode == MODE_HOLD) begin
      if (b[BTN_W-1]) begin
        if (s.hold_cnt >= s.hold_ticks) begin
          s.mode         = MODE_SET;
          s.digits       = '0;
          s.hold_cnt     = '0;
          s.release_wait = 1'b1;
          r.event_res    = EV_SETMODE;
        end else begin
          s.hold_cnt = s.hold_cnt + 1'b1;
        end
        return r;
      end
      s.mode     = MODE_ENTRY;
      s.hold_cnt = '0;
      r = take_digit(s, KEY_EIGHT);
      s.release_wait = (b != '0);
      return r;
    end
    key = lowest_key(b);
    if (key == '0) begin
      return r;
    end
    if (s.mode == MODE_SET) begin
      r.position  = s.digits[POS_W-1:0];
      r.key_value = key;
      r.event_res = EV_CODEDIGIT;
      s.stored[s.digits] = key;
      s.digits = s.digits + 5'd1;
      if (s.digits >= CODE_LENGTH) begin
        s.digits    = '0;
        s.mode      = MODE_ENTRY;
        r.event_res = EV_SAVED;
      end
      s.release_wait = 1'b1;
      return r;
    end
    if (s.digits == '0 && b == BTN_KEY8_ONLY) begin
      s.mode     = MODE_HOLD;
      s.hold_cnt = HOLD_W'(1);
      return r;
    end
    r = take_digit(s, key);
    s.release_wait = 1'b1;
    return r;
  endfunction

  function automatic void push_sample(input logic [BTN_W-1:0] b);
    btn_q.push_back(b);
    void'(lock_step(gst, b));
    n_pushed++;
  endfunction

  function automatic void press_key(input int k);
    logic [BTN_W-1:0] v;
    int               reps;
    v = BTN_W'(1 << (k - 1));
    if ($urandom_range(2) == 0) begin
      v = v | BTN_W'($urandom & ~((1 << k) - 1));
    end
    reps = (gst.mode == MODE_ENTRY && gst.digits == '0 && v == BTN_KEY8_ONLY) ?
           1 : $urandom_range(1, 3);
    repeat (reps) push_sample(v);
    repeat ($urandom_range(1, 2)) push_sample('0);
  endfunction

  function automatic void settle();
    while (gst.release_wait || gst.mode == MODE_HOLD) begin
      push_sample('0);
    end
  endfunction

  function automatic void to_entry_start();
    settle();
    while (gst.mode == MODE_SET || gst.digits != '0) begin
      press_key($urandom_range(1, BTN_W));
    end
  endfunction

  function automatic void change_code();
    to_entry_start();
    push_sample(BTN_KEY8_ONLY);
    while (gst.mode == MODE_HOLD) begin
      push_sample(BTN_KEY8_ONLY | BTN_W'($urandom_range(1) ? $urandom_range(127) : 0));
    end
    repeat ($urandom_range(0, 2)) push_sample(BTN_W'($urandom_range(1, 255)));
    settle();
    while (gst.mode == MODE_SET) begin
      press_key($urandom_range(1, BTN_W));
    end
  endfunction

  function automatic void fill_random(input int amount);
    int                                start;
    int                                pick;
    int                                idx;
    int                                extra;
    logic [CODE_LENGTH-1:0][KEY_W-1:0] guess;
    start = n_pushed;
    while (n_pushed - start < amount) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        to_entry_start();
        for (int i = 0; i < CODE_LENGTH; i++) begin
          press_key(gst.stored[i]);
        end
      end else if (pick < 55) begin
        to_entry_start();
        guess = gst.stored;
        if ($urandom_range(1) == 0) begin
          idx = $urandom_range(CODE_LENGTH - 1);
          guess[idx] = KEY_W'(guess[idx] % 8 + 1);
        end else begin
          for (int i = 0; i < CODE_LENGTH; i++) begin
            guess[i] = KEY_W'($urandom_range(1, BTN_W));
          end
        end
        for (int i = 0; i < CODE_LENGTH; i++) begin
          press_key(guess[i]);
        end
      end else if (pick < 67) begin
        repeat ($urandom_range(1, 6)) push_sample(BTN_W'($urandom));
      end else if (pick < 86) begin
        to_entry_start();
        push_sample(BTN_KEY8_ONLY);
        extra = (gst.hold_ticks > 20) ? 19 : (gst.hold_ticks > 1) ? gst.hold_ticks - 1 : 0;
        repeat ($urandom_range(0, extra)) begin
          if (gst.mode == MODE_HOLD) begin
            push_sample(BTN_KEY8_ONLY | BTN_W'($urandom_range(1) ? $urandom_range(127) : 0));
          end
        end
        push_sample($urandom_range(1) ? '0 : BTN_W'($urandom_range(1, 127)));
      end else if (gst.hold_ticks <= 64 || pick == 99) begin
        change_code();
      end else begin
        settle();
        repeat ($urandom_range(1, CODE_LENGTH - 1)) press_key($urandom_range(1, BTN_W));
      end
    end
  endfunction

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_hold(input logic [HOLD_W-1:0] ticks);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, PADDR_W'(4 * int'(REG_HOLD_TICKS)), PDATA_W'(ticks), rd);
    apb_access(1'b0, PADDR_W'(4 * int'(REG_HOLD_TICKS)), '0, rd);
    if (rd[HOLD_W-1:0] !== ticks) begin
      report_mismatch("hold_ticks readback", rd, PDATA_W'(ticks));
    end
    chk_st.hold_ticks = ticks;
    gst.hold_ticks    = ticks;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid   <= 1'b0;
      drv_buttons <= '0;
    end else if (!drv_valid || btn_ch.ready) begin
      if (btn_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_valid   <= 1'b1;
        drv_buttons <= btn_q.pop_front();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      if (btn_ch.valid && btn_ch.ready) begin
        lock_q.push_back(lock_step(chk_st, btn_ch.buttons));
      end
      if (res_ch.valid && res_ch.ready) begin
        n_out++;
        if (lock_q.size() == 0) begin
          report_mismatch("event with no sample pending", 32'(res_ch.event_res), '0);
        end else begin
          due = lock_q.pop_front();
          ev_count[due.event_res]++;
          if (res_ch.event_res !== due.event_res) begin
            report_mismatch("event_res", 32'(res_ch.event_res), 32'(due.event_res));
          end
          if (res_ch.position !== due.position) begin
            report_mismatch("position", 32'(res_ch.position), 32'(due.position));
          end
          if (res_ch.key_value !== due.key_value) begin
            report_mismatch("key_value", 32'(res_ch.key_value), 32'(due.key_value));
          end
          if (res_ch.relay_pulse !== due.relay_pulse) begin
            report_mismatch("relay_pulse", 32'(res_ch.relay_pulse), 32'(due.relay_pulse));
          end
        end
      end
      rcv_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((btn_ch.valid && btn_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [PDATA_W-1:0] rd;
    logic [HOLD_W-1:0]  ht;
    logic [HOLD_W-1:0]  mid_ht;
    chk_st = lock_reset();
    gst    = lock_reset();
    mid_ht = HOLD_W'($urandom_range(2, 40));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, PADDR_W'(4 * int'(REG_HOLD_TICKS)), '0, rd);
    if (rd[HOLD_W-1:0] !== HOLD_TICKS_RST) begin
      report_mismatch("hold_ticks after reset", rd, PDATA_W'(HOLD_TICKS_RST));
    end
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          ht = '0;
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          ht = HOLD_W'(1);
          send_idle_pct = 70;
          stall_pct     = 0;
        end
        2: begin
          ht = '1;
          send_idle_pct = 0;
          stall_pct     = 70;
        end
        3: begin
          ht = mid_ht;
          send_idle_pct = 33;
          stall_pct     = 33;
        end
        default: begin
          ht = HOLD_TICKS_RST;
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      program_hold(ht);
      if (ph == 0) begin
        foreach (DIRECTED_SEQ[i]) push_sample(DIRECTED_SEQ[i]);
      end
      if (ph == 2) begin
        change_code();
      end
      fill_random((ph == 2) ? 40 : 100);
      // hold the sender until every event of this phase has come back
      while (n_out != n_pushed) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (lock_q.size() != 0) begin
      report_mismatch("events never delivered", 32'(lock_q.size()), '0);
    end
    $display("%0d samples, %0d events: %0d digits, %0d unlocks, %0d rejects, %0d set-mode",
             n_pushed, n_out, ev_count[EV_DIGIT], ev_count[EV_UNLOCK], ev_count[EV_REJECT],
             ev_count[EV_SETMODE]);
    $display("%0d code digits, %0d code saves; hold_ticks 0, 1, 1023, %0d, 200 under stalls",
             ev_count[EV_CODEDIGIT], ev_count[EV_SAVED], mid_ht);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
